// ===== rtl/daqesd_pkg.sv =====
// Shared types and constants for the event stream decoder.
`timescale 1ns / 1ps

package daqesd_pkg;

    localparam int HDR_LEN = 32;
    localparam int HDR_POS_W = $clog2(HDR_LEN);
    localparam logic [HDR_POS_W-1:0] LAST_HDR_POS = HDR_POS_W'(HDR_LEN - 1);
    localparam logic [2:0] LAST_PHASE = 3'd5;
    localparam logic [23:0] IDX_MAX = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        REC_HEADER   = 2'd0,
        REC_SPECTRUM = 2'd1,
        REC_WAVEFORM = 2'd2
    } rec_kind_t;

    typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_t;

    typedef struct packed {
        logic [31:0] ltn;
        logic [7:0]  chan;
        logic [15:0] run;
        logic [7:0]  ttype;
        logic [7:0]  mod_id;
        logic [31:0] tcb_count;
        logic [33:0] tcb_time;
        logic [31:0] pattern;
        logic [57:0] gate;
        logic [31:0] body_len;
        logic        fresh;
        logic        mism;
    } hdr_info_t;

endpackage

// ===== rtl/daqesd_hdr_calc.sv =====
// Header field decode: times, body length and trigger flags.
`timescale 1ns / 1ps

module daqesd_hdr_calc
    import daqesd_pkg::*;
(
    input  hdr_bytes_t  hdr,
    input  logic [31:0] prev_trig,
    input  logic [57:0] prev_gate,
    input  logic        have_prev,
    output hdr_info_t   info
);

    logic [23:0] tcb_coarse;
    logic [47:0] gate_coarse;
    logic [33:0] tcb_x;
    logic [57:0] gate_x;
    logic [31:0] ev_len;

    assign tcb_coarse  = {hdr[14], hdr[13], hdr[12]};
    assign gate_coarse = {hdr[31], hdr[30], hdr[29], hdr[28], hdr[27], hdr[26]};
    assign tcb_x       = {10'd0, tcb_coarse};
    assign gate_x      = {10'd0, gate_coarse};
    assign ev_len      = {hdr[3], hdr[2], hdr[1], hdr[0]};

    always_comb
    begin
        info.ltn       = {hdr[20], hdr[19], hdr[18], hdr[17]};
        info.chan      = hdr[16];
        info.run       = {hdr[5], hdr[4]};
        info.ttype     = hdr[6];
        info.mod_id    = hdr[15];
        info.tcb_count = {hdr[10], hdr[9], hdr[8], hdr[7]};
        // x * 1000 = x * 1024 - x * 16 - x * 8
        info.tcb_time  = {23'd0, hdr[11], 3'd0} + (tcb_x << 10) - (tcb_x << 4)
                         - (tcb_x << 3);
        info.pattern   = {hdr[24], hdr[23], hdr[22], hdr[21]};
        info.gate      = {47'd0, hdr[25], 3'd0} + (gate_x << 10) - (gate_x << 4)
                         - (gate_x << 3);
        info.body_len  = (ev_len > 32'(HDR_LEN)) ? ev_len - 32'(HDR_LEN) : 32'd0;
        info.fresh     = !have_prev || (info.ltn != prev_trig);
        info.mism      = !info.fresh && (info.gate != prev_gate);
    end

endmodule

// ===== rtl/daq_event_stream_decoder.sv =====
// Top level of the digitizer event stream decoder.
`timescale 1ns / 1ps

// Takes one stream byte per clock while byte_stall is low, and gives at
// most one record per byte, registered in the cycle after the byte is taken.
// The 32nd byte of each event yields the header record; body bytes then
// yield spectrum records (channel 0, one per 6-byte group, at most 32) or
// waveform samples (one per byte pair). The only hold on the byte side
// comes from the single output register: byte_stall is high while a record
// waits there and record_stall is high. There is no startup delay after reset.
module daq_event_stream_decoder
    import daqesd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         stream_byte,
    output logic               record_valid,
    input  logic               record_stall,
    output logic [1:0]         record_kind,
    output logic [31:0]        trigger_number,
    output logic [7:0]         channel,
    output logic [15:0]        run_id,
    output logic [7:0]         trig_kind,
    output logic [7:0]         module_id,
    output logic [31:0]        tcb_trigger_count,
    output logic [33:0]        tcb_time,
    output logic [31:0]        trigger_pattern,
    output logic [57:0]        gate_time,
    output logic signed [24:0] amplitude,
    output logic [23:0]        detail
);

    logic [7:0] hdr_reg [HDR_LEN-1];

    logic                 in_body_reg, in_body_next;
    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [31:0]          remaining_reg, remaining_next;
    logic [2:0]           phase_reg, phase_next;
    logic [5:0]           group_reg, group_next;
    logic [39:0]          asm_reg, asm_next;
    logic [23:0]          sample_reg, sample_next;
    logic [31:0]          prev_trig_reg, prev_trig_next;
    logic [57:0]          prev_gate_reg, prev_gate_next;
    logic                 have_prev_reg, have_prev_next;

    logic                 out_valid_reg;
    rec_kind_t            kind_reg, kind_next;
    logic [31:0]          ltn_reg, ltn_next;
    logic [7:0]           chan_reg, chan_next;
    logic [15:0]          run_reg, run_next;
    logic [7:0]           ttype_reg, ttype_next;
    logic [7:0]           mod_reg, mod_next;
    logic [31:0]          tcbcnt_reg, tcbcnt_next;
    logic [33:0]          tcbt_reg, tcbt_next;
    logic [31:0]          pat_reg, pat_next;
    logic [57:0]          gate_reg, gate_next;
    logic signed [24:0]   amp_reg, amp_next;
    logic [23:0]          det_reg, det_next;

    logic       accept;
    logic       emit;
    logic       hdr_we;
    hdr_bytes_t hdr_view;
    hdr_info_t  info;

    assign byte_stall = out_valid_reg && record_stall;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        for (int i = 0; i < HDR_LEN - 1; i++)
        begin
            hdr_view[i] = hdr_reg[i];
        end
        hdr_view[HDR_LEN-1] = stream_byte;
    end

    daqesd_hdr_calc u_hdr_calc (
        .hdr       (hdr_view),
        .prev_trig (prev_trig_reg),
        .prev_gate (prev_gate_reg),
        .have_prev (have_prev_reg),
        .info      (info)
    );

    always_comb
    begin
        in_body_next   = in_body_reg;
        hdr_pos_next   = hdr_pos_reg;
        remaining_next = remaining_reg;
        phase_next     = phase_reg;
        group_next     = group_reg;
        asm_next       = asm_reg;
        sample_next    = sample_reg;
        prev_trig_next = prev_trig_reg;
        prev_gate_next = prev_gate_reg;
        have_prev_next = have_prev_reg;
        hdr_we         = 1'b0;
        emit           = 1'b0;

        kind_next   = REC_HEADER;
        ltn_next    = info.ltn;
        chan_next   = info.chan;
        run_next    = '0;
        ttype_next  = '0;
        mod_next    = '0;
        tcbcnt_next = '0;
        tcbt_next   = '0;
        pat_next    = '0;
        gate_next   = '0;
        amp_next    = '0;
        det_next    = '0;

        if (accept)
        begin
            if (!in_body_reg)
            begin
                if (hdr_pos_reg != LAST_HDR_POS)
                begin
                    hdr_we       = 1'b1;
                    hdr_pos_next = hdr_pos_reg + 1'b1;
                end
                else
                begin
                    hdr_pos_next   = '0;
                    remaining_next = info.body_len;
                    in_body_next   = (info.body_len != 32'd0);
                    phase_next     = '0;
                    group_next     = '0;
                    asm_next       = '0;
                    sample_next    = '0;
                    if (info.fresh)
                    begin
                        prev_trig_next = info.ltn;
                        prev_gate_next = info.gate;
                        have_prev_next = 1'b1;
                    end
                    emit        = 1'b1;
                    kind_next   = REC_HEADER;
                    run_next    = info.run;
                    ttype_next  = info.ttype;
                    mod_next    = info.mod_id;
                    tcbcnt_next = info.tcb_count;
                    tcbt_next   = info.tcb_time;
                    pat_next    = info.pattern;
                    gate_next   = info.gate;
                    det_next    = {22'd0, info.mism, info.fresh};
                end
            end
            else
            begin
                if (info.chan == 8'd0)
                begin
                    case (phase_reg)
                        3'd0:    asm_next = {32'd0, stream_byte};
                        3'd1:    asm_next[15:8]  = stream_byte;
                        3'd2:    asm_next[23:16] = stream_byte;
                        3'd3:    asm_next[31:24] = stream_byte;
                        3'd4:    asm_next[39:32] = stream_byte;
                        default: asm_next = asm_reg;
                    endcase
                    if (phase_reg == LAST_PHASE)
                    begin
                        phase_next = '0;
                        if (!group_reg[5])
                        begin
                            emit       = 1'b1;
                            kind_next  = REC_SPECTRUM;
                            chan_next  = {3'd0, group_reg[4:0]};
                            amp_next   = {1'b0, asm_reg[23:0]};
                            det_next   = {stream_byte, asm_reg[39:24]};
                            group_next = group_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next = {2'd0, ~phase_reg[0]};
                    if (!phase_reg[0])
                    begin
                        asm_next = {32'd0, stream_byte};
                    end
                    else
                    begin
                        emit      = 1'b1;
                        kind_next = REC_WAVEFORM;
                        amp_next  = 25'(signed'({stream_byte, asm_reg[7:0]}));
                        det_next  = sample_reg;
                        if (sample_reg != IDX_MAX)
                        begin
                            sample_next = sample_reg + 1'b1;
                        end
                    end
                end

                if (remaining_reg == 32'd1)
                begin
                    in_body_next   = 1'b0;
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[hdr_pos_reg] <= stream_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg   <= 1'b0;
            hdr_pos_reg   <= '0;
            remaining_reg <= '0;
            phase_reg     <= '0;
            group_reg     <= '0;
            asm_reg       <= '0;
            sample_reg    <= '0;
            prev_trig_reg <= '0;
            prev_gate_reg <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_body_reg   <= in_body_next;
            hdr_pos_reg   <= hdr_pos_next;
            remaining_reg <= remaining_next;
            phase_reg     <= phase_next;
            group_reg     <= group_next;
            asm_reg       <= asm_next;
            sample_reg    <= sample_next;
            prev_trig_reg <= prev_trig_next;
            prev_gate_reg <= prev_gate_next;
            have_prev_reg <= have_prev_next;
            if (!out_valid_reg || !record_stall)
            begin
                out_valid_reg <= accept && emit;
            end
        end
    end

    // Load the result register only when it is free and a record is made.
    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || !record_stall) && accept && emit)
        begin
            kind_reg   <= kind_next;
            ltn_reg    <= ltn_next;
            chan_reg   <= chan_next;
            run_reg    <= run_next;
            ttype_reg  <= ttype_next;
            mod_reg    <= mod_next;
            tcbcnt_reg <= tcbcnt_next;
            tcbt_reg   <= tcbt_next;
            pat_reg    <= pat_next;
            gate_reg   <= gate_next;
            amp_reg    <= amp_next;
            det_reg    <= det_next;
        end
    end

    assign record_valid      = out_valid_reg;
    assign record_kind       = kind_reg;
    assign trigger_number    = ltn_reg;
    assign channel           = chan_reg;
    assign run_id            = run_reg;
    assign trig_kind         = ttype_reg;
    assign module_id         = mod_reg;
    assign tcb_trigger_count = tcbcnt_reg;
    assign tcb_time          = tcbt_reg;
    assign trigger_pattern   = pat_reg;
    assign gate_time         = gate_reg;
    assign amplitude         = amp_reg;
    assign detail            = det_reg;

endmodule
